@@ rtl/kmhc_pkg.sv @@
`default_nettype none

package kmhc_pkg;

    localparam int MAX_KMER    = 8;
    localparam int WIN_W       = 2 * MAX_KMER;
    localparam int ADDR_W      = WIN_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CNT_W       = 32;
    localparam int K_W         = 4;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CNT_W-1:0]  COUNT_MAX      = '1;
    localparam logic [CHAR_W-1:0] BASE_MASK      = 8'h06;
    localparam logic [K_W-1:0]    KMER_LEN_RESET = K_W'(MAX_KMER);

    // register index taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_KMER_LENGTH = '0;

    typedef enum logic {
        OP_INC,
        OP_READ
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [ADDR_W-1:0] addr;
    } req_t;

    // zero acts as one, anything above the maximum is clamped
    function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] len);
        logic [K_W-1:0] k;
        k = len;
        if (len == '0)
        begin
            k = K_W'(1);
        end
        else if (len > K_W'(MAX_KMER))
        begin
            k = K_W'(MAX_KMER);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/kmhc_ram.sv @@
`default_nettype none

module kmhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/kmhc_window.sv @@
`default_nettype none

module kmhc_window
    import kmhc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              action,
    input  wire logic [CHAR_W-1:0] base_char,
    input  wire logic              first_of_sequence,
    input  wire logic [IDX_W-1:0]  kmer_index,
    input  wire logic [K_W-1:0]    kmer_length,
    output req_t                   req
);

    logic [WIN_W-1:0]  window_reg;
    logic [WIN_W-1:0]  window_next;
    logic [K_W-1:0]    fill_reg;
    logic [K_W-1:0]    fill_next;
    logic [K_W-1:0]    k;
    logic [WIN_W-1:0]  mask;
    logic [CHAR_W-1:0] masked_char;
    logic [1:0]        code;
    logic [WIN_W-1:0]  window_base;
    logic [K_W-1:0]    fill_base;
    logic [31:0]       idx_ext;
    logic              counting;

    always_comb
    begin
        k           = eff_k(kmer_length);
        masked_char = base_char & BASE_MASK;
        code        = masked_char[2:1];
        for (int i = 0; i < MAX_KMER; i++)
        begin
            mask[2*i +: 2] = {2{K_W'(i) < k}};
        end
        window_base = first_of_sequence ? '0 : window_reg;
        fill_base   = first_of_sequence ? '0 : fill_reg;
        window_next = WIN_W'({window_base, code}) & mask;
        fill_next   = (fill_base < k) ? fill_base + K_W'(1) : k;
        counting    = (fill_next >= k);
        idx_ext     = {{(32 - IDX_W){1'b0}}, kmer_index};

        req.valid = accept && (action || counting);
        req.op    = action ? OP_READ : OP_INC;
        req.addr  = action ? idx_ext[ADDR_W-1:0] : window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept && !action)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/kmhc_rmw.sv @@
`default_nettype none

module kmhc_rmw
    import kmhc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire req_t              req,
    output logic                   ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CNT_W-1:0]  count_value
);

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_hit_reg;
    logic [CNT_W-1:0]  s1_fwd_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  old_count;
    logic [CNT_W-1:0]  new_count;
    logic              s1_we;
    logic              out_load_ok;
    logic              s1_advance;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;

    always_comb
    begin
        // a write at the edge of the read is not seen by the ram read port
        old_count   = s1_hit_reg ? s1_fwd_reg : ram_rdata;
        new_count   = (old_count == COUNT_MAX) ? old_count : old_count + CNT_W'(1);
        s1_we       = s1_valid_reg && (s1_op_reg == OP_INC);
        out_load_ok = !out_valid_reg || out_ready;
        s1_advance  = !s1_valid_reg || (s1_op_reg == OP_INC) || out_load_ok;
        ready       = !clr_active_reg && s1_advance;
        ram_we      = clr_active_reg || s1_we;
        ram_waddr   = clr_active_reg ? clr_addr_reg : s1_addr_reg;
        ram_wdata   = clr_active_reg ? '0 : new_count;
    end

    kmhc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req.valid),
        .raddr (req.addr),
        .rdata (ram_rdata)
    );

    // zero sweep over the whole store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            s1_op_reg   <= req.op;
            s1_addr_reg <= req.addr;
            s1_hit_reg  <= s1_we && (s1_addr_reg == req.addr);
            s1_fwd_reg  <= new_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && (s1_op_reg == OP_READ) && out_load_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (s1_op_reg == OP_READ) && out_load_ok)
        begin
            count_reg <= old_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign count_value = count_reg;

endmodule

`default_nettype wire

@@ rtl/kmer_histogram_counter_top.sv @@
// read path: a read goes from the ram read register through s1 to count_value
// throughput: one item per cycle while in_ready is high, feed or read; the counter
//   rmw is one ram read and one ram write per cycle, forwarding on address hits
// reset: async active low; window, fill level and kmer_length (8) reset at once,
//   then the store zeroing sweeps all 65536 words, during which in_ready stays low
`default_nettype none

module kmer_histogram_counter_top
    import kmhc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic [CHAR_W-1:0]  base_char,
    input  wire logic               first_of_sequence,
    input  wire logic [IDX_W-1:0]   kmer_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [CNT_W-1:0]   count_value,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [K_W-1:0] kmer_length_reg;
    logic           cfg_wr;
    logic           in_accept;
    req_t           req;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LEN_RESET;
        end
        else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_KMER_LENGTH))
        begin
            kmer_length_reg <= pwdata[K_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_KMER_LENGTH)
        begin
            prdata = {{(PDATA_W - K_W){1'b0}}, kmer_length_reg};
        end
    end

    kmhc_window u_window (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .action            (action),
        .base_char         (base_char),
        .first_of_sequence (first_of_sequence),
        .kmer_index        (kmer_index),
        .kmer_length       (kmer_length_reg),
        .req               (req)
    );

    kmhc_rmw u_rmw (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ready       (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .count_value (count_value)
    );

endmodule

`default_nettype wire

@@ rtl/kmhc_checker.sv @@
`default_nettype none

module kmhc_checker
    import kmhc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               action,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [CNT_W-1:0]   count_value
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count_value))
    else $error("count_value changed while stalled");

    // store zeroing keeps the input closed right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("block open before store zeroing");

    // a new result comes from an accepted read transfer that has passed through s1
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && action, 2))
    else $error("result without matching read transfer");

endmodule

bind kmer_histogram_counter_top kmhc_checker u_kmhc_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import kmhc_pkg::*;

    localparam bit ACT_FEED = 1'b0;
    localparam bit ACT_READ = 1'b1;

    // shadow of the block: window, fill level, length register and all counters
    class kmer_scoreboard;
        logic [K_W-1:0]    kmer_len;
        logic [WIN_W-1:0]  window;
        logic [K_W-1:0]    fill;
        bit   [CNT_W-1:0]  counts [STORE_DEPTH];
        logic [CNT_W-1:0]  pending_counts [$];
        int                errors;

        function new();
            kmer_len = KMER_LEN_RESET;
            window   = '0;
            fill     = '0;
            errors   = 0;
        endfunction

        function int unsigned active_length();
            int unsigned k;
            k = kmer_len;
            if (k < 1)
            begin
                k = 1;
            end
            if (k > MAX_KMER)
            begin
                k = MAX_KMER;
            end
            return k;
        endfunction

        function logic [WIN_W-1:0] window_mask();
            logic [31:0] m;
            m = (32'd1 << (2 * active_length())) - 32'd1;
            return m[WIN_W-1:0];
        endfunction

        function void set_length(input logic [K_W-1:0] len);
            kmer_len = len;
        endfunction

        function void note_transfer(input bit act, input logic [CHAR_W-1:0] ch,
                                    input bit first, input logic [IDX_W-1:0] idx);
            int unsigned k;
            logic [1:0] code;
            logic [ADDR_W-1:0] slot;
            if (act == ACT_READ)
            begin
                slot = idx[ADDR_W-1:0];
                pending_counts.push_back(counts[slot]);
                return;
            end
            k = active_length();
            code = 2'((ch & BASE_MASK) >> 1);
            if (first)
            begin
                window = '0;
                fill   = '0;
            end
            window = ((window << 2) | WIN_W'(code)) & window_mask();
            if (fill < k)
            begin
                fill = fill + 1'b1;
            end
            else
            begin
                fill = K_W'(k);
            end
            if (fill >= k)
            begin
                slot = window;
                if (counts[slot] != COUNT_MAX)
                begin
                    counts[slot] = counts[slot] + 1;
                end
            end
        endfunction

        function void check_count(input logic [CNT_W-1:0] got);
            logic [CNT_W-1:0] want;
            if (pending_counts.size() == 0)
            begin
                $error("count_value: expected none, actual %0h", got);
                errors++;
                return;
            end
            want = pending_counts.pop_front();
            if (got !== want)
            begin
                $error("count_value: expected %0h, actual %0h", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [CHAR_W-1:0]  base_char;
    logic               first_of_sequence;
    logic [IDX_W-1:0]   kmer_index;
    logic               out_valid;
    logic               out_ready;
    logic [CNT_W-1:0]   count_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    kmer_scoreboard sb;
    bit             idle_on;
    int             seq_left;

    kmer_histogram_counter_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .base_char         (base_char),
        .first_of_sequence (first_of_sequence),
        .kmer_index        (kmer_index),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .count_value       (count_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_item(input bit act, input logic [CHAR_W-1:0] ch,
                             input bit first, input logic [IDX_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        action            <= act;
        base_char         <= ch;
        first_of_sequence <= first;
        kmer_index        <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_transfer(act, ch, first, idx);
    endtask

    task automatic feed_text(input string s, input bit restart);
        for (int i = 0; i < s.len(); i++)
        begin
            push_item(ACT_FEED, s[i], restart && (i == 0), IDX_W'($urandom));
        end
    endtask

    // called in the step of the last accepted transfer; feeds leave no result behind
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_kmer_length(input logic [K_W-1:0] len);
        logic [PDATA_W-1:0] junk;
        junk    = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KMER_LENGTH, 2'b00};
        pwdata  <= {junk[PDATA_W-1:K_W], len};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_length(len);
        @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_base();
        logic [CHAR_W-1:0] c;
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: c = "A";
            1: c = "C";
            2: c = "G";
            default: c = "T";
        endcase
        if (r >= 70 && r < 85)
        begin
            c = c | 8'h20;
        end
        else if (r >= 85 && r < 90)
        begin
            c = (r[0]) ? "N" : "n";
        end
        else if (r >= 90)
        begin
            c = CHAR_W'($urandom);
        end
        return c;
    endfunction

    task automatic run_random(input int n);
        bit               act;
        bit               first;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        int               r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 30 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            ch    = CHAR_W'($urandom);
            first = 1'($urandom);
            idx   = IDX_W'($urandom);
            if ($urandom_range(0, 99) < 30)
            begin
                act = ACT_READ;
                r = $urandom_range(0, 3);
                if (r < 2)
                begin
                    idx = sb.window;
                end
                else if (r == 2)
                begin
                    idx = idx & sb.window_mask();
                end
            end
            else
            begin
                act = ACT_FEED;
                ch  = pick_base();
                if (seq_left == 0)
                begin
                    first    = 1'b1;
                    seq_left = $urandom_range(1, 24);
                end
                else
                begin
                    // occasional restart in the middle of a sequence
                    first = ($urandom_range(0, 99) < 3);
                end
                seq_left--;
            end
            push_item(act, ch, first, idx);
        end
    endtask

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_count(count_value);
                stall = idle_on ? $urandom_range(0, 5) : 0;
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned lengths [12] = '{1, 0, 15, 3, 8, 5, 9, 2, 7, 4, 6, 13};
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        action            = ACT_FEED;
        base_char         = '0;
        first_of_sequence = 1'b0;
        kmer_index        = '0;
        out_ready         = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        idle_on           = 1'b1;
        seq_left          = 0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // store clearing pass holds in_ready low
        @(posedge clk);
        while (!in_ready) @(posedge clk);

        // directed part at the reset length
        push_item(ACT_READ, 8'h00, 1'b0, '0);
        push_item(ACT_READ, 8'hFF, 1'b1, '1);
        feed_text("ACGTACGTNacgt", 1'b1);
        push_item(ACT_READ, 8'h00, 1'b0, sb.window);
        push_item(ACT_FEED, 8'h00, 1'b0, '1);
        push_item(ACT_FEED, 8'hFF, 1'b0, '0);
        push_item(ACT_FEED, "G", 1'b1, '1);
        push_item(ACT_READ, 8'hFF, 1'b1, sb.window);
        push_item(ACT_READ, 8'h00, 1'b0, '1);
        drain_block();

        // sequences carry over between phases, so the length changes mid-sequence
        for (int p = 0; p < 12; p++)
        begin
            write_kmer_length(K_W'(lengths[p]));
            run_random(78);
            drain_block();
        end

        if (sb.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
